/* hdl/b2da_pkg.sv */
// Shared constants and types for the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

  localparam int unsigned VALUE_W          = 64;
  localparam int unsigned CHAR_W           = 6;
  localparam int unsigned BCD_W            = 4;
  localparam int unsigned VALUE_BITS_DEF   = 64;
  localparam int unsigned DIGITS_DEF       = 20;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 6'd48;
  localparam logic [BCD_W-1:0]  DABBLE_LIMIT = 4'd5;
  localparam logic [BCD_W-1:0]  DABBLE_ADD   = 4'd3;

  // Commands from the sequencer to the BCD digit register.
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift_digit;
    logic in_bit;
  } bcd_ctrl_t;

endpackage

`default_nettype wire

/* hdl/b2da_if.sv */
// Channel interfaces for the binary value input and the character output.
`default_nettype none

interface b2da_in_if;
  logic                         valid;
  logic                         ready;
  logic [b2da_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
  logic                        valid;
  logic                        ready;
  logic [b2da_pkg::CHAR_W-1:0] digit_char;
  logic                        last_char;

  modport source (output valid, output digit_char, output last_char, input ready);
  modport sink   (input valid, input digit_char, input last_char, output ready);
endinterface

`default_nettype wire

/* hdl/b2da_bcd_reg.sv */
// BCD digit register: double dabble step, digit shift toward the top, clear.
`default_nettype none

module b2da_bcd_reg #(
  parameter int unsigned DIGITS = b2da_pkg::DIGITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire b2da_pkg::bcd_ctrl_t        ctrl_i,
  output logic [b2da_pkg::BCD_W-1:0]      top_digit_o
);

  logic [DIGITS-1:0][b2da_pkg::BCD_W-1:0] bcd_q;
  logic [DIGITS-1:0][b2da_pkg::BCD_W-1:0] bcd_d;
  logic [DIGITS-1:0][b2da_pkg::BCD_W-1:0] adj;
  logic [DIGITS-1:0][b2da_pkg::BCD_W-1:0] dabbled;

  // Each digit adjusts on its own; only the shifted-out bit links neighbors.
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_q[d] >= b2da_pkg::DABBLE_LIMIT) begin
        adj[d] = bcd_q[d] + b2da_pkg::DABBLE_ADD;
      end else begin
        adj[d] = bcd_q[d];
      end
    end
    dabbled[0] = {adj[0][2:0], ctrl_i.in_bit};
    for (int d = 1; d < DIGITS; d++) begin
      dabbled[d] = {adj[d][2:0], adj[d-1][3]};
    end
  end

  always_comb begin
    bcd_d = bcd_q;
    if (ctrl_i.clear) begin
      bcd_d = '0;
    end else if (ctrl_i.dabble) begin
      bcd_d = dabbled;
    end else if (ctrl_i.shift_digit) begin
      bcd_d = {bcd_q[DIGITS-2:0], {b2da_pkg::BCD_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
    end else begin
      bcd_q <= bcd_d;
    end
  end

  assign top_digit_o = bcd_q[DIGITS-1];

endmodule

`default_nettype wire

/* hdl/binary_to_decimal_ascii.sv */
// Top level: bit-serial binary to decimal ASCII converter with digit output.
//
//   Channel  Dir  Payload                  Transfer when
//   in_i     in   value[63:0]              in_i.valid && in_i.ready
//   out_o    out  digit_char[5:0], last    out_o.valid && out_o.ready
//
// A value is accepted, then takes VALUE_BITS double dabble steps, one input
// bit per cycle; the sequencer then shifts out each suppressed leading zero
// digit and after that emits each remaining digit in turn.
// The digits leave serially through the top of the BCD digit register.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// A stalled output holds the digit sequencer; input is taken only when idle.
`default_nettype none

module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int unsigned DIGITS     = b2da_pkg::DIGITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2da_in_if.sink    in_i,
  b2da_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS);
  localparam int unsigned REM_W = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e                        state_q;
  logic [VALUE_BITS-1:0]         bin_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [REM_W-1:0]              rem_q;
  logic                          out_valid_q;
  logic [b2da_pkg::CHAR_W-1:0]   out_char_q;
  logic                          out_last_q;

  b2da_pkg::bcd_ctrl_t           bcd_ctrl;
  logic [b2da_pkg::BCD_W-1:0]    top_digit;
  logic                          skip_zero;
  logic                          load_out;

  assign skip_zero = (state_q == S_SKIP) && (top_digit == '0) && (rem_q > REM_W'(1));
  assign load_out  = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    bcd_ctrl.clear       = (state_q == S_IDLE) && in_i.valid;
    bcd_ctrl.dabble      = (state_q == S_CONV);
    bcd_ctrl.shift_digit = skip_zero || load_out;
    bcd_ctrl.in_bit      = bin_q[VALUE_BITS-1];
  end

  b2da_bcd_reg #(
    .DIGITS (DIGITS)
  ) u_bcd_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (bcd_ctrl),
    .top_digit_o (top_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cnt_q   <= CNT_W'(VALUE_BITS - 1);
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            rem_q   <= REM_W'(DIGITS);
            state_q <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_zero) begin
            rem_q <= rem_q - REM_W'(1);
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            rem_q <= rem_q - REM_W'(1);
            if (rem_q == REM_W'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_i.valid) begin
      bin_q <= in_i.value[VALUE_BITS-1:0];
    end else if (state_q == S_CONV) begin
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
    end
    if (load_out) begin
      out_char_q <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
      out_last_q <= (rem_q == REM_W'(1));
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last_char  = out_last_q;

endmodule

`default_nettype wire
